/* design/dq_pkg.sv */
// Package for the double-ended queue: payload types, operation codes,
// status codes and the sequencer state type. Depends on nothing.
package dq_pkg;

	// Payload field types as seen on the channels.
	typedef logic [2:0]         kind_t;
	typedef logic signed [31:0] word_t;
	typedef logic [1:0]         status_t;
	typedef logic [5:0]         count_t;

	// Operation codes carried in the kind field.
	localparam kind_t KIND_PUSH_FRONT = 3'd0;
	localparam kind_t KIND_PUSH_BACK  = 3'd1;
	localparam kind_t KIND_POP_FRONT  = 3'd2;
	localparam kind_t KIND_POP_BACK   = 3'd3;
	localparam kind_t KIND_CONTAINS   = 3'd4;
	localparam kind_t KIND_REMOVE     = 3'd5;

	// Status codes returned with every result.
	localparam status_t STATUS_DONE  = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EXEC     = 7'b0000010,
		ST_SEARCH   = 7'b0000100,
		ST_SHIFT    = 7'b0001000,
		ST_RD_FRONT = 7'b0010000,
		ST_RD_BACK  = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

endpackage

/* design/dq_cmd_if.sv */
// Command channel of the double-ended queue: valid/ready plus the
// operation and its value. Depends on dq_pkg.
interface dq_cmd_if import dq_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	word_t entry_value;

	modport source (output valid, output kind, output entry_value, input ready);
	modport sink (input valid, input kind, input entry_value, output ready);
endinterface

/* design/dq_rsp_if.sv */
// Response channel of the double-ended queue: valid/ready plus the
// status and the state summary after each operation. Depends on dq_pkg.
interface dq_rsp_if import dq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	logic    found;
	word_t   front_value;
	word_t   back_value;
	count_t  entry_count;
	logic    is_empty;

	modport source (output valid, output status, output found, output front_value,
		output back_value, output entry_count, output is_empty, input ready);
	modport sink (input valid, input status, input found, input front_value,
		input back_value, input entry_count, input is_empty, output ready);
endinterface

/* design/dq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; depends on nothing.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

/* design/double_ended_queue.sv */
// Bounded double-ended queue of words kept as a ring buffer in one RAM.
// Top level; depends on dq_pkg, dq_cmd_if, dq_rsp_if and dq_ram.
//
// The queue holds up to DEPTH words of VALUE_WIDTH bits and takes one command
// beat at a time: push front, push back, pop front, pop back, contains, or
// remove the first match counted from the front. Every command gives one
// response beat with the status, the found flag, the front and back words
// (zero when empty), the count and an empty flag. For pushes and pops the
// sequencer first updates the pointers or writes the RAM, then reads the front
// and back words through the RAM's registered read port, then loads the
// response register that presents the response beat; that load waits while an
// earlier response has not been taken. Contains walks the entries from the
// front with one RAM read per cycle until it finds a match or passes the back
// entry. Remove then reads each later word and writes it back one place toward
// the front; no word is moved when the match is the back entry. The single RAM
// port pair sets this order of steps.
// A new command is taken only once the previous one is finished; the response
// register lets the next command start while a response still waits.
module double_ended_queue import dq_pkg::*; #(
	parameter int DEPTH       = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	dq_cmd_if.sink   cmd,
	dq_rsp_if.source rsp
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef logic [AW-1:0]          addr_t;
	typedef logic [CW-1:0]          cnt_t;
	typedef logic [VALUE_WIDTH-1:0] val_t;

	// Ring address of the entry at a given offset from the front.
	function automatic addr_t slot(input addr_t h, input cnt_t k);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(k);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return AW'(s);
	endfunction

	state_t        state_q;
	kind_t         kind_q;
	val_t          value_q;
	addr_t         head_q;
	cnt_t          count_q;
	status_t       status_q;
	logic          found_q;
	cnt_t          ik_q;
	cnt_t          ck_q;
	logic          rv_q;
	logic [31:0]   front_q;
	logic          rsp_valid_q;
	status_t       rsp_status_q;
	logic          rsp_found_q;
	logic [31:0]   rsp_front_q;
	logic [31:0]   rsp_back_q;
	count_t        rsp_count_q;
	logic          rsp_empty_q;

	logic          we;
	addr_t         waddr;
	val_t          wdata;
	logic          re;
	addr_t         raddr;
	val_t          rdata;

	logic          is_full;
	logic          is_zero;
	logic          match;
	logic          issue;
	logic          rsp_load;
	addr_t         head_dec;

	dq_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_zero  = (count_q == '0);
	assign match    = rv_q && (rdata == value_q);
	assign issue    = (ik_q < count_q);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	assign cmd.ready = (state_q == ST_IDLE);

	// RAM port control for each step of the sequencer.
	always_comb begin
		we    = 1'b0;
		waddr = slot(head_q, ck_q);
		wdata = rdata;
		re    = 1'b0;
		raddr = slot(head_q, ik_q);
		case (state_q)
			ST_EXEC: begin
				case (kind_q)
					KIND_PUSH_FRONT: begin
						we    = !is_full;
						waddr = head_dec;
						wdata = value_q;
					end
					KIND_PUSH_BACK: begin
						we    = !is_full;
						waddr = slot(head_q, count_q);
						wdata = value_q;
					end
					KIND_CONTAINS, KIND_REMOVE: begin
						re    = !is_zero;
						raddr = head_q;
					end
					default: begin
					end
				endcase
			end
			ST_SEARCH: begin
				re = !match && issue;
			end
			ST_SHIFT: begin
				we = rv_q;
				re = issue;
			end
			ST_RD_FRONT: begin
				re    = !is_zero;
				raddr = head_q;
			end
			ST_RD_BACK: begin
				re    = !is_zero;
				raddr = slot(head_q, count_q - 1'b1);
			end
			default: begin
			end
		endcase
	end

	// Sequencer and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			rv_q    <= 1'b0;
			ik_q    <= '0;
			ck_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RD_FRONT;
					case (kind_q)
						KIND_PUSH_FRONT: begin
							if (!is_full) begin
								head_q  <= head_dec;
								count_q <= count_q + 1'b1;
							end
						end
						KIND_PUSH_BACK: begin
							if (!is_full) begin
								count_q <= count_q + 1'b1;
							end
						end
						KIND_POP_FRONT: begin
							if (!is_zero) begin
								head_q  <= slot(head_q, CW'(1));
								count_q <= count_q - 1'b1;
							end
						end
						KIND_POP_BACK: begin
							if (!is_zero) begin
								count_q <= count_q - 1'b1;
							end
						end
						KIND_CONTAINS, KIND_REMOVE: begin
							if (!is_zero) begin
								ik_q    <= CW'(1);
								ck_q    <= '0;
								rv_q    <= 1'b1;
								state_q <= ST_SEARCH;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SEARCH: begin
					if (match) begin
						rv_q <= 1'b0;
						if (kind_q == KIND_REMOVE) begin
							ik_q    <= ck_q + 1'b1;
							state_q <= ST_SHIFT;
						end else begin
							state_q <= ST_RD_FRONT;
						end
					end else if (rv_q && (ck_q == count_q - 1'b1)) begin
						rv_q    <= 1'b0;
						state_q <= ST_RD_FRONT;
					end else begin
						rv_q <= issue;
						if (issue) begin
							ik_q <= ik_q + 1'b1;
							ck_q <= ik_q;
						end
					end
				end
				ST_SHIFT: begin
					// Each word read here lands one place toward the front next cycle.
					if (issue) begin
						ik_q <= ik_q + 1'b1;
						ck_q <= ik_q - 1'b1;
						rv_q <= 1'b1;
					end else begin
						rv_q <= 1'b0;
						if (!rv_q) begin
							count_q <= count_q - 1'b1;
							state_q <= ST_RD_FRONT;
						end
					end
				end
				ST_RD_FRONT: begin
					state_q <= ST_RD_BACK;
				end
				ST_RD_BACK: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command capture, status, found flag and the front word.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_q   <= cmd.kind;
			value_q  <= VALUE_WIDTH'($unsigned(cmd.entry_value));
			status_q <= STATUS_DONE;
			found_q  <= 1'b0;
		end
		if (state_q == ST_EXEC) begin
			if ((kind_q == KIND_PUSH_FRONT || kind_q == KIND_PUSH_BACK) && is_full) begin
				status_q <= STATUS_FULL;
			end
			if ((kind_q == KIND_POP_FRONT || kind_q == KIND_POP_BACK) && is_zero) begin
				status_q <= STATUS_EMPTY;
			end
		end
		if (state_q == ST_SEARCH && match) begin
			found_q <= 1'b1;
		end
		if (state_q == ST_RD_BACK) begin
			front_q <= is_zero ? 32'd0 : 32'(rdata);
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_found_q  <= found_q;
			rsp_front_q  <= front_q;
			rsp_back_q   <= is_zero ? 32'd0 : 32'(rdata);
			rsp_count_q  <= 6'(count_q);
			rsp_empty_q  <= is_zero;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.back_value  = rsp_back_q;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_empty    = rsp_empty_q;

	// The count never moves while no command is in progress.
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(count_q))
		else $error("entry count changed while idle");

	// A full status is only reported when the queue is at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && (status_q == STATUS_FULL) |=> (rsp_count_q == 6'(DEPTH)))
		else $error("full status with a queue below capacity");

	// The block is busy, not ready, in the cycle after a command beat.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command accepted on consecutive cycles");

	// The count held never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond capacity");
endmodule
